FILE: rtl/three_rotor_substitution_cipher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-rotor substitution cipher
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, checked at every edge outside reset
`define RCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every edge outside reset
`define RCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_pkg
// Constants, types and letter arithmetic for the three-rotor cipher.
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int unsigned RCP_LETTERS   = 26;
    localparam int unsigned RCP_OUT_DEPTH = 8;

    typedef logic [4:0] letter_t;
    typedef logic [7:0] byte_t;

    // Character bounds
    localparam byte_t CH_LOWER_A = 8'h61;
    localparam byte_t CH_LOWER_Z = 8'h7a;
    localparam byte_t CH_UPPER_A = 8'h41;
    localparam byte_t CH_UPPER_Z = 8'h5a;

    // Item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_CIPHER = 1'b1;

    // Rotor select codes
    localparam logic [1:0] ROTOR_FIRST  = 2'd0;
    localparam logic [1:0] ROTOR_SECOND = 2'd1;
    localparam logic [1:0] ROTOR_THIRD  = 2'd2;
    localparam logic [1:0] ROTOR_NONE   = 2'd3;

    // Per-item side data carried down the lookup pipeline
    typedef struct packed {
        logic    letter;
        logic    upper;
        byte_t   ch;
        letter_t p2;
        letter_t p3;
    } stage_t;

    // Sum of two letter numbers (both below 26), wrapped into 0..25
    function automatic letter_t add_mod26(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'(RCP_LETTERS))
            s = s - 6'(RCP_LETTERS);
        return s[4:0];
    endfunction

    // Reduce a 5-bit value into 0..25
    function automatic letter_t mod26(input letter_t v);
        letter_t r;
        r = v;
        if (v >= 5'(RCP_LETTERS))
            r = v - 5'(RCP_LETTERS);
        return r;
    endfunction

endpackage

FILE: rtl/three_rotor_substitution_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_top
// Three-rotor substitution cipher with odometer stepping, no reflector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per cycle. A load item
//   (command 0) with a valid rotor and index writes one rotor table entry
//   and clears all rotor positions; it gives no result. A cipher item
//   (command 1) gives exactly one char_out on the output channel
//   (out_valid/out_ready), in item order. Letters map through the three
//   rotor tables in the same case; other bytes pass unchanged and do not
//   step the rotors. The first table read is at the accepting edge; the
//   second and third reads follow in turn, then the result enters the queue.
//   Throughput: one item per cycle while in_ready is high; the three rotor
//   RAMs each serve one lookup stage, and positions are updated at accept.
//   When the receiver stalls, results collect in an OUT_DEPTH-entry queue;
//   in_ready drops once queued plus in-flight items reach OUT_DEPTH.
//   OUT_DEPTH of 5 or more keeps the full rate with out_ready held high.
//   Reset clears positions, pipeline and queue; rotor tables are undefined
//   until loaded.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_top
    import rcp_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = RCP_OUT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [1:0] rotor_select,
    input  logic [4:0] entry_index,
    input  logic [4:0] entry_value,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out
);

    localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int unsigned TOT_W = $clog2(OUT_DEPTH + 4);

    logic    in_fire;
    logic    is_lower;
    logic    is_upper;
    logic    is_letter;
    letter_t letter_x;
    logic    load_ok;
    letter_t load_val;
    logic    we1, we2, we3;

    logic    w3_valid_reg;
    letter_t w3_index_reg;
    letter_t w3_value_reg;

    letter_t p1_reg, p2_reg, p3_reg;
    letter_t p1_next, p2_next, p3_next;

    letter_t raddr1, raddr2, raddr3;
    letter_t rdata1, rdata2, rdata3;

    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    stage_t  s1_reg, s2_reg, s3_reg;
    stage_t  s0_info;
    byte_t   result;

    byte_t            fifo_mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;
    logic [TOT_W-1:0] in_flight;
    logic             push, pop;

    // Decode the incoming item
    assign in_fire   = in_valid && in_ready;
    assign is_lower  = (char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_Z);
    assign is_upper  = (char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_Z);
    assign is_letter = is_lower || is_upper;
    assign letter_x  = is_upper ? 5'(char_in - CH_UPPER_A) : 5'(char_in - CH_LOWER_A);
    assign load_ok   = (command == CMD_LOAD) && (rotor_select != ROTOR_NONE)
                       && (entry_index < 5'(RCP_LETTERS));
    assign load_val  = mod26(entry_value);

    assign we1 = in_fire && load_ok && (rotor_select == ROTOR_FIRST);
    assign we2 = in_fire && load_ok && (rotor_select == ROTOR_SECOND);
    assign we3 = in_fire && load_ok && (rotor_select == ROTOR_THIRD);

    // Register third-rotor writes so an earlier item's third read
    // still sees the old entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w3_valid_reg <= 1'b0;
            w3_index_reg <= '0;
            w3_value_reg <= '0;
        end
        else
        begin
            w3_valid_reg <= we3;
            w3_index_reg <= entry_index;
            w3_value_reg <= load_val;
        end
    end

    // Advance positions odometer-style on a cipher letter, clear on a valid load
    always_comb
    begin
        p1_next = p1_reg;
        p2_next = p2_reg;
        p3_next = p3_reg;
        if (in_fire && load_ok)
        begin
            p1_next = '0;
            p2_next = '0;
            p3_next = '0;
        end
        else if (in_fire && (command == CMD_CIPHER) && is_letter)
        begin
            if (p1_reg == 5'(RCP_LETTERS - 1))
            begin
                p1_next = '0;
                if (p2_reg == 5'(RCP_LETTERS - 1))
                begin
                    p2_next = '0;
                    p3_next = (p3_reg == 5'(RCP_LETTERS - 1)) ? '0 : p3_reg + 5'd1;
                end
                else
                begin
                    p2_next = p2_reg + 5'd1;
                end
            end
            else
            begin
                p1_next = p1_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    // Lookup addresses: the first stage adds its rotor offset to the letter, each later stage to the previous read
    assign raddr1 = add_mod26(letter_x, p1_reg);
    assign raddr2 = add_mod26(rdata1, s1_reg.p2);
    assign raddr3 = add_mod26(rdata2, s2_reg.p3);

    rcp_ram #(.WIDTH(5), .DEPTH(RCP_LETTERS)) u_rotor1 (
        .clk   (clk),
        .we    (we1),
        .waddr (entry_index),
        .wdata (load_val),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    rcp_ram #(.WIDTH(5), .DEPTH(RCP_LETTERS)) u_rotor2 (
        .clk   (clk),
        .we    (we2),
        .waddr (entry_index),
        .wdata (load_val),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    rcp_ram #(.WIDTH(5), .DEPTH(RCP_LETTERS)) u_rotor3 (
        .clk   (clk),
        .we    (w3_valid_reg),
        .waddr (w3_index_reg),
        .wdata (w3_value_reg),
        .raddr (raddr3),
        .rdata (rdata3)
    );

    // Capture item info with the positions in force before this item steps
    always_comb
    begin
        s0_info.letter = is_letter;
        s0_info.upper  = is_upper;
        s0_info.ch     = char_in;
        s0_info.p2     = p2_reg;
        s0_info.p3     = p3_reg;
    end

    // Lookup pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire && (command == CMD_CIPHER);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Lookup pipeline payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s0_info;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
    end

    // Restore case, or pass the byte through
    assign result = s3_reg.letter
                    ? ((s3_reg.upper ? CH_UPPER_A : CH_LOWER_A) + {3'b000, rdata3})
                    : s3_reg.ch;

    // Result queue
    assign push = s3_valid_reg;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign out_valid = (fifo_cnt_reg != '0);
    assign char_out  = fifo_mem_reg[rd_ptr_reg];

    // Hold off input once every queue slot is spoken for
    assign in_flight = TOT_W'(fifo_cnt_reg) + TOT_W'(s1_valid_reg)
                       + TOT_W'(s2_valid_reg) + TOT_W'(s3_valid_reg);
    assign in_ready  = (in_flight < TOT_W'(OUT_DEPTH));

endmodule

FILE: rtl/rcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module rcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read in the same edge; a read sees the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/rcp_checker.sv
`timescale 1ns / 1ps
`include "three_rotor_substitution_cipher_top_macros.svh"
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks on the three-rotor cipher, bound to its top level.
// ----------------------------------------------------------------------------
module rcp_checker
    import rcp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       cipher_fire;
    logic       out_fire;

    // Track cipher items accepted but not yet delivered
    assign cipher_fire = in_valid && in_ready && (command == CMD_CIPHER);
    assign out_fire    = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 8'(cipher_fire) - 8'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Hold a stalled result
    `RCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(char_out), "stalled result changed or dropped")

    // Never show a result no cipher item asked for
    `RCP_ASSERT_IMPL(a_no_invent, clk, rst_n, out_valid, pending_reg != 8'd0, "result without an outstanding cipher item")

    // Accept input whenever nothing is outstanding
    `RCP_ASSERT_IMPL(a_ready_idle, clk, rst_n, pending_reg == 8'd0, in_ready, "input stalled while block is empty")

endmodule

bind three_rotor_substitution_cipher_top rcp_checker u_rcp_checker (.*);
